// ===== design/frequency_sweep_link_watchdog_fsm_core_assert.svh =====
// Assertion macros shared by the sweep controller RTL.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef FREQUENCY_SWEEP_LINK_WATCHDOG_FSM_CORE_ASSERT_SVH
`define FREQUENCY_SWEEP_LINK_WATCHDOG_FSM_CORE_ASSERT_SVH

// Same-cycle implication.
`define FSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fswlw_pkg.sv =====
package fswlw_pkg;

    // Width of the internal millisecond time base.
    localparam int TIME_BITS = 32;

    localparam int MS_W     = 32;
    localparam int PERIOD_W = 16;
    localparam int FREQ_W   = 17;
    localparam int STEP_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [FREQ_W-1:0]    freq_t;
    typedef logic [PERIOD_W-1:0]  period_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVE_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FREQ     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP    = 3'd6;

    // Reset values of the configuration registers.
    localparam period_t RST_LINK_TIMEOUT = 16'd1500;
    localparam period_t RST_SWEEP_PERIOD = 16'd10;
    localparam period_t RST_LIVE_PERIOD  = 16'd50;
    localparam period_t RST_IDLE_PERIOD  = 16'd1000;
    localparam freq_t   RST_START_FREQ   = 17'd30000;
    localparam freq_t   RST_END_FREQ     = 17'd35000;
    localparam logic [STEP_W-1:0] RST_FREQ_STEP = 10'd50;

endpackage

// ===== design/frequency_sweep_link_watchdog_fsm_core.sv =====
// Sweep controller with link watchdog, one step per request.
//
// Channels:
//   s_*   : step requests. s_tdata carries now_ms and last_rx_ms, s_tuser the
//           host scan request flag.
//   m_*   : one result per step: state after the step, drive start/stop and
//           clear strobes, telemetry event and its frequency; m_tuser marks a
//           live report versus an idle flatline event.
//   cfg_* : register writes (index, data); always ready. Write only while no
//           step is in flight.
// Pipeline: a request accepted on s_* sits in the input register, then moves
// on into the result register, from which m_* presents it.
// Throughput: one request per cycle while the result stage drains; the
// single-pass step logic between the input and result registers sets that figure.
// Stall: while m_tready is low the result holds and the input register still
// takes one more request; s_tready drops only when both stages are full.
// Reset: registers return to their default values, the machine goes idle,
// both time stamps clear and the frequency returns to 30000 Hz. No result
// is pending after reset.
module frequency_sweep_link_watchdog_fsm_core
    import fswlw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // step request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms, [63:32] last_rx_ms
    input  logic                  s_tuser,   // [0] scan_request
    // step result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] sweep_state, [2] drive_start,
                                             // [3] drive_stop, [4] clear_request,
                                             // [5] telemetry_valid,
                                             // [22:6] telemetry_freq_hz, [23] zero
    output logic                  m_tuser,   // [0] telemetry_live
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_INIT     = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_STOPPING = 2'd3
    } mode_t;

    // configuration
    period_t            link_timeout_reg;
    period_t            sweep_period_reg;
    period_t            live_period_reg;
    period_t            idle_period_reg;
    freq_t              start_freq_reg;
    freq_t              end_freq_reg;
    logic [STEP_W-1:0]  freq_step_reg;

    // sweep state
    mode_t              mode_reg,        mode_next;
    time_t              last_step_reg,   last_step_next;
    time_t              last_report_reg, last_report_next;
    freq_t              freq_now_reg,    freq_now_next;

    // input stage
    logic               in_valid_reg;
    logic [MS_W-1:0]    in_now_reg;
    logic [MS_W-1:0]    in_rx_reg;
    logic               in_req_reg;

    // result stage
    logic               out_valid_reg;
    logic [1:0]         out_state_reg;
    logic               out_start_reg,  out_start_next;
    logic               out_stop_reg,   out_stop_next;
    logic               out_clr_reg,    out_clr_next;
    logic               out_tvalid_reg, out_tvalid_next;
    logic               out_live_reg,   out_live_next;
    freq_t              out_freq_reg,   out_freq_next;

    logic               advance;
    time_t              now_t;
    time_t              rx_t;
    time_t              since_rx;
    time_t              since_step;
    time_t              since_report;
    logic [FREQ_W:0]    freq_sum;
    mode_t              mode_eff;

    // Move the input stage forward whenever the result stage is free or drains.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_live_reg;
    assign m_tdata  = {1'b0, out_freq_reg, out_tvalid_reg, out_clr_reg, out_stop_reg,
                       out_start_reg, out_state_reg};

    // Wrapping time differences.
    assign now_t        = TIME_BITS'(in_now_reg);
    assign rx_t         = TIME_BITS'(in_rx_reg);
    assign since_rx     = now_t - rx_t;
    assign since_step   = now_t - last_step_reg;
    assign since_report = now_t - last_report_reg;
    assign freq_sum     = {1'b0, freq_now_reg} + (FREQ_W + 1)'(freq_step_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        last_step_next   = last_step_reg;
        last_report_next = last_report_reg;
        freq_now_next    = freq_now_reg;
        out_start_next   = 1'b0;
        out_stop_next    = 1'b0;
        out_clr_next     = 1'b0;
        out_tvalid_next  = 1'b0;
        out_live_next    = 1'b0;
        out_freq_next    = '0;

        // Watchdog: link silence beyond the timeout stops a running sweep now.
        mode_eff = mode_reg;
        if (mode_reg == MODE_RUNNING && since_rx > TIME_BITS'(link_timeout_reg))
        begin
            mode_eff = MODE_STOPPING;
        end

        case (mode_eff)
            MODE_IDLE:
            begin
                if (in_req_reg)
                begin
                    mode_next = MODE_INIT;
                end
                else if (since_report >= TIME_BITS'(idle_period_reg))
                begin
                    out_tvalid_next  = 1'b1;
                    last_report_next = now_t;
                end
            end
            MODE_INIT:
            begin
                freq_now_next    = start_freq_reg;
                out_start_next   = 1'b1;
                last_step_next   = now_t;
                last_report_next = now_t;
                mode_next        = MODE_RUNNING;
            end
            MODE_RUNNING:
            begin
                if (!in_req_reg)
                begin
                    mode_next = MODE_STOPPING;
                end
                else
                begin
                    if (since_step >= TIME_BITS'(sweep_period_reg))
                    begin
                        last_step_next = now_t;
                        freq_now_next  = (freq_sum > {1'b0, end_freq_reg}) ?
                                         start_freq_reg : freq_sum[FREQ_W-1:0];
                    end
                    // Report the frequency as it stands after this step.
                    if (since_report >= TIME_BITS'(live_period_reg))
                    begin
                        out_tvalid_next  = 1'b1;
                        out_live_next    = 1'b1;
                        out_freq_next    = freq_now_next;
                        last_report_next = now_t;
                    end
                end
            end
            default:
            begin
                out_stop_next = 1'b1;
                out_clr_next  = 1'b1;
                mode_next     = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_timeout_reg <= RST_LINK_TIMEOUT;
            sweep_period_reg <= RST_SWEEP_PERIOD;
            live_period_reg  <= RST_LIVE_PERIOD;
            idle_period_reg  <= RST_IDLE_PERIOD;
            start_freq_reg   <= RST_START_FREQ;
            end_freq_reg     <= RST_END_FREQ;
            freq_step_reg    <= RST_FREQ_STEP;
            mode_reg         <= MODE_IDLE;
            last_step_reg    <= '0;
            last_report_reg  <= '0;
            freq_now_reg     <= RST_START_FREQ;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // Register writes; indexes past the list drop silently.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINK_TIMEOUT: link_timeout_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_SWEEP_PERIOD: sweep_period_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_LIVE_PERIOD:  live_period_reg  <= cfg_data[PERIOD_W-1:0];
                    CFG_IDLE_PERIOD:  idle_period_reg  <= cfg_data[PERIOD_W-1:0];
                    CFG_START_FREQ:   start_freq_reg   <= cfg_data[FREQ_W-1:0];
                    CFG_END_FREQ:     end_freq_reg     <= cfg_data[FREQ_W-1:0];
                    CFG_FREQ_STEP:    freq_step_reg    <= cfg_data[STEP_W-1:0];
                    default:          ;
                endcase
            end

            // Capture a new request.
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_now_reg   <= s_tdata[MS_W-1:0];
                in_rx_reg    <= s_tdata[2*MS_W-1:MS_W];
                in_req_reg   <= s_tuser;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // Commit the step and load the result.
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    mode_reg        <= mode_next;
                    last_step_reg   <= last_step_next;
                    last_report_reg <= last_report_next;
                    freq_now_reg    <= freq_now_next;
                    out_state_reg   <= mode_next;
                    out_start_reg   <= out_start_next;
                    out_stop_reg    <= out_stop_next;
                    out_clr_reg     <= out_clr_next;
                    out_tvalid_reg  <= out_tvalid_next;
                    out_live_reg    <= out_live_next;
                    out_freq_reg    <= out_freq_next;
                end
            end
        end
    end

`include "frequency_sweep_link_watchdog_fsm_core_assert.svh"

    `FSW_ASSERT_NOW(a_start_stop_excl, out_valid_reg, !(out_start_reg && out_stop_reg), "drive start and stop in one step")
    `FSW_ASSERT_NOW(a_live_has_event, out_valid_reg && out_live_reg, out_tvalid_reg, "live kind without telemetry event")
    `FSW_ASSERT_NOW(a_freq_only_live, out_valid_reg && !out_live_reg, out_freq_reg == '0, "frequency reported outside live event")
    `FSW_ASSERT_NOW(a_start_to_run, out_valid_reg && out_start_reg, out_state_reg == MODE_RUNNING, "drive start without running state")
    `FSW_ASSERT_NEXT(a_commit_mode, advance && in_valid_reg, mode_reg == $past(mode_next), "state not committed with result")

endmodule

// ===== tb/sweep_step_checker.sv =====
`timescale 1ns / 100ps

module sweep_step_checker
    import fswlw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms, [63:32] last_rx_ms
    input  logic                  s_tuser,   // [0] scan_request
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] sweep_state, [2] drive_start,
                                             // [3] drive_stop, [4] clear_request,
                                             // [5] telemetry_valid,
                                             // [22:6] telemetry_freq_hz, [23] zero
    input  logic                  m_tuser,   // [0] telemetry_live
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    open_steps
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_INIT,
        MODE_RUNNING,
        MODE_STOPPING
    } sweep_mode_t;

    typedef struct packed {
        sweep_mode_t state;
        logic        drive_start;
        logic        drive_stop;
        logic        clear_request;
        logic        tel_valid;
        logic        tel_live;
        freq_t       tel_freq;
    } step_result_t;

    // Register copies
    period_t           timeout_ms;
    period_t           sweep_ms;
    period_t           live_ms;
    period_t           idle_ms;
    freq_t             start_hz;
    freq_t             stop_hz;
    logic [STEP_W-1:0] step_hz;

    // Controller state
    sweep_mode_t mode;
    time_t       last_step_ms;
    time_t       last_report_ms;
    freq_t       freq_hz;

    step_result_t step_results[$];

    // One pass of the controller; time differences wrap at 32 bits.
    function automatic step_result_t sweep_step(time_t now, time_t rx, logic req);
        step_result_t     r;
        logic [FREQ_W:0]  next_hz;
        r = '0;
        if (mode == MODE_RUNNING && (now - rx) > timeout_ms)
            mode = MODE_STOPPING;
        case (mode)
            MODE_IDLE:
            begin
                if (req)
                    mode = MODE_INIT;
                else if ((now - last_report_ms) >= idle_ms)
                begin
                    r.tel_valid    = 1'b1;
                    last_report_ms = now;
                end
            end
            MODE_INIT:
            begin
                freq_hz        = start_hz;
                r.drive_start  = 1'b1;
                last_step_ms   = now;
                last_report_ms = now;
                mode           = MODE_RUNNING;
            end
            MODE_RUNNING:
            begin
                if (!req)
                    mode = MODE_STOPPING;
                else
                begin
                    if ((now - last_step_ms) >= sweep_ms)
                    begin
                        next_hz      = freq_hz + step_hz;
                        last_step_ms = now;
                        freq_hz      = (next_hz > {1'b0, stop_hz}) ? start_hz
                                                                   : next_hz[FREQ_W-1:0];
                    end
                    if ((now - last_report_ms) >= live_ms)
                    begin
                        r.tel_valid    = 1'b1;
                        r.tel_live     = 1'b1;
                        r.tel_freq     = freq_hz;
                        last_report_ms = now;
                    end
                end
            end
            default:
            begin
                r.drive_stop    = 1'b1;
                r.clear_request = 1'b1;
                mode            = MODE_IDLE;
            end
        endcase
        r.state = mode;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_result_t want;
        if (!rst_n)
        begin
            timeout_ms     = RST_LINK_TIMEOUT;
            sweep_ms       = RST_SWEEP_PERIOD;
            live_ms        = RST_LIVE_PERIOD;
            idle_ms        = RST_IDLE_PERIOD;
            start_hz       = RST_START_FREQ;
            stop_hz        = RST_END_FREQ;
            step_hz        = RST_FREQ_STEP;
            mode           = MODE_IDLE;
            last_step_ms   = '0;
            last_report_ms = '0;
            freq_hz        = RST_START_FREQ;
            mismatches     = 0;
            step_results.delete();
            open_steps    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINK_TIMEOUT: timeout_ms = cfg_data[PERIOD_W-1:0];
                    CFG_SWEEP_PERIOD: sweep_ms   = cfg_data[PERIOD_W-1:0];
                    CFG_LIVE_PERIOD:  live_ms    = cfg_data[PERIOD_W-1:0];
                    CFG_IDLE_PERIOD:  idle_ms    = cfg_data[PERIOD_W-1:0];
                    CFG_START_FREQ:   start_hz   = cfg_data[FREQ_W-1:0];
                    CFG_END_FREQ:     stop_hz    = cfg_data[FREQ_W-1:0];
                    CFG_FREQ_STEP:    step_hz    = cfg_data[STEP_W-1:0];
                    default:          ;
                endcase
            end
            // Retire the oldest step before queuing a new one
            if (m_tvalid && m_tready)
            begin
                if (step_results.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = step_results.pop_front();
                    check_field("sweep_state", want.state, m_tdata[1:0]);
                    check_field("drive_start", want.drive_start, m_tdata[2]);
                    check_field("drive_stop", want.drive_stop, m_tdata[3]);
                    check_field("clear_request", want.clear_request, m_tdata[4]);
                    check_field("telemetry_valid", want.tel_valid, m_tdata[5]);
                    check_field("telemetry_freq_hz", want.tel_freq, m_tdata[FREQ_W+5:6]);
                    check_field("tdata_pad", 0, m_tdata[OUT_DATA_W-1]);
                    check_field("telemetry_live", want.tel_live, m_tuser);
                end
            end
            if (s_tvalid && s_tready)
                step_results.push_back(sweep_step(s_tdata[MS_W-1:0],
                                                  s_tdata[2*MS_W-1:MS_W], s_tuser));
            open_steps <= step_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import fswlw_pkg::*;
();

    // Index past the last register; writes to it must leave every register alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    // Input and result registers in the pipeline; give it slack after the last result
    localparam int DRAIN_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [31:0] now_ms, [63:32] last_rx_ms
    logic                  s_tuser;   // [0] scan_request
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;   // [1:0] sweep_state, [2] drive_start,
                                      // [3] drive_stop, [4] clear_request,
                                      // [5] telemetry_valid,
                                      // [22:6] telemetry_freq_hz, [23] zero
    logic                  m_tuser;   // [0] telemetry_live
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          mismatches;
    int          open_steps;
    int          idle_pct = 20;     // chance in percent of an idle burst, both sides
    int          stall_left = 0;
    int unsigned cycle_count = 0;

    // Stimulus-side view of time, link and host request
    time_t   wall_ms = '0;
    period_t link_timeout = RST_LINK_TIMEOUT;
    logic    scan_req = 1'b0;

    frequency_sweep_link_watchdog_fsm_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sweep_step_checker u_sweep_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .open_steps (open_steps)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hold reset at the start, then release it for good
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: stall in random bursts, otherwise stay ready
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(4);
        end
        else
            m_tready <= 1'b1;
    end

    // Offer one step request, maybe after an idle burst, and hold it until taken
    task automatic send_step(time_t now, time_t rx, logic req);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        s_tdata  <= {rx, now};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Leave cfg_valid high between back-to-back writes; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write every register; values wider than a register get truncated by the block
    task automatic set_config(logic [CFG_DATA_W-1:0] timeout, logic [CFG_DATA_W-1:0] sweep,
                              logic [CFG_DATA_W-1:0] live, logic [CFG_DATA_W-1:0] idle,
                              logic [CFG_DATA_W-1:0] start, logic [CFG_DATA_W-1:0] stop,
                              logic [CFG_DATA_W-1:0] step);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(17'h1FFFF)));
        write_reg(CFG_LINK_TIMEOUT, timeout);
        write_reg(CFG_SWEEP_PERIOD, sweep);
        write_reg(CFG_LIVE_PERIOD, live);
        write_reg(CFG_IDLE_PERIOD, idle);
        write_reg(CFG_START_FREQ, start);
        write_reg(CFG_END_FREQ, stop);
        write_reg(CFG_FREQ_STEP, step);
        cfg_valid    <= 1'b0;
        link_timeout  = timeout[PERIOD_W-1:0];
    endtask

    // Drop the request line, wait for every result, then let the pipeline settle.
    // The first edge lets the checker count the request taken at this one.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_steps != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random steps: time mostly creeps forward, the link is mostly alive and the
    // host request flips now and then, so sweeps run long enough to wrap.
    task automatic run_phase(int count, int unsigned gap_ms, int pct);
        time_t       silence;
        int unsigned pick;
        idle_pct = pct;
        scan_req = 1'b1;
        repeat (count)
        begin
            if ($urandom_range(99) < 3)
                wall_ms += $urandom();
            else
                wall_ms += $urandom_range(gap_ms);
            pick = $urandom_range(99);
            if (pick < 92)
                silence = $urandom_range(link_timeout);
            else if (pick < 95)
                silence = link_timeout;
            else if (pick < 98)
                silence = link_timeout + 1;
            else
                silence = $urandom();
            if ($urandom_range(99) < 4)
                scan_req = !scan_req;
            send_step(wall_ms, wall_ms - silence, scan_req);
        end
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        wait (rst_n);
        @(posedge clk);

        // Directed walk with reset settings: flatline, start, steps, reports,
        // watchdog at and past the limit, request drop, time wrap, link ahead of now
        send_step(32'd0, 32'd0, 1'b0);
        send_step(32'd999, 32'd999, 1'b0);
        send_step(32'd1000, 32'd1000, 1'b0);
        send_step(32'd1000, 32'd1000, 1'b1);
        send_step(32'd1005, 32'd1005, 1'b1);
        send_step(32'd1014, 32'd1014, 1'b1);
        send_step(32'd1015, 32'd1015, 1'b1);
        send_step(32'd1055, 32'd1055, 1'b1);
        send_step(32'd2555, 32'd1055, 1'b1);
        send_step(32'd4056, 32'd2555, 1'b1);
        send_step(32'd4057, 32'd4057, 1'b1);
        send_step(32'd4058, 32'd4058, 1'b1);
        send_step(32'd4060, 32'd4060, 1'b0);
        send_step(32'd4061, 32'd4061, 1'b1);
        send_step(32'd4062, 32'd4062, 1'b1);
        send_step(32'hFFFF_FFF0, 32'hFFFF_FFF0, 1'b1);
        send_step(32'h0000_0010, 32'hFFFF_FFFF, 1'b1);
        send_step(32'h0000_0030, 32'h0000_0030, 1'b1);
        send_step(32'h0000_0031, 32'h0000_0040, 1'b1);
        send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_step(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_step(32'hAAAA_5555, 32'h5555_AAAA, 1'b0);
        drain();

        // Reset settings, random traffic
        wall_ms = $urandom();
        run_phase(150, 30, 20);
        drain();

        // Small periods and a narrow band so the sweep wraps often
        set_config(17'd200, 17'd3, 17'd7, 17'd15, 17'd30000, 17'd30400, 17'd100);
        run_phase(250, 8, 10);
        drain();

        // Lower extremes: zero timeout, zero periods and zero step through truncation
        set_config(17'd0, 17'h10000, 17'h10000, 17'h10000, 17'd0, 17'd0, 17'h400);
        run_phase(150, 3, 25);
        drain();

        // Upper extremes: start above end, widest step
        set_config(17'd65535, 17'd65535, 17'd65535, 17'd65535, 17'h1FFFF, 17'd100000,
                   17'd1023);
        run_phase(150, 40000, 0);
        drain();

        // Top of the frequency range, unit periods: every step wraps
        set_config(17'd1, 17'd1, 17'd1, 17'd1, 17'd100000, 17'd100000, 17'd1);
        run_phase(150, 3, 15);
        drain();

        // Random settings; the last phase runs with no idling at all
        for (int p = 0; p < 4; p++)
        begin
            logic [CFG_DATA_W-1:0] start_pick;
            logic [CFG_DATA_W-1:0] sweep_pick;
            start_pick = CFG_DATA_W'($urandom_range(100000));
            sweep_pick = CFG_DATA_W'($urandom_range(20));
            set_config(CFG_DATA_W'($urandom_range(2000, 20)), sweep_pick,
                       CFG_DATA_W'($urandom_range(60)), CFG_DATA_W'($urandom_range(200)),
                       start_pick,
                       ($urandom_range(3) == 0)
                           ? CFG_DATA_W'($urandom_range(17'h1FFFF))
                           : CFG_DATA_W'(start_pick + $urandom_range(5000)),
                       CFG_DATA_W'($urandom_range(1000, 1)));
            run_phase(200, 2 * sweep_pick + 30, (p == 3) ? 0 : $urandom_range(2) * 15);
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
